>>> hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants
// Codes, field widths and the sequencer state type of the gain-scheduled
// PID core.
// ----------------------------------------------------------------------------
package gsp_pkg;

	localparam int SIG_W  = 16;
	localparam int ERR_W  = 17;
	localparam int DIFF_W = 18;
	localparam int INT_W  = 32;
	localparam int DER_W  = 34;
	localparam int MA_W   = 35;
	localparam int MB_W   = 17;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 44;

	typedef logic [1:0] func_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic signed [SIG_W-1:0] sig_t;

	localparam func_t FN_STEP   = 2'd0;
	localparam func_t FN_APPEND = 2'd1;
	localparam func_t FN_CLEAR  = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NO_REGION = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	localparam cfg_idx_t CFG_STEP_TIME = 2'd0;
	localparam cfg_idx_t CFG_RATE_HZ   = 2'd1;
	localparam cfg_idx_t CFG_CLEAR_SW  = 2'd2;
	localparam cfg_idx_t CFG_WINDUP    = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_MUL_INC,
		S_MUL_DRV,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_ADD_D,
		S_CLAMP,
		S_DONE
	} gsp_state_t;

endpackage

>>> hdl/gsp_cmd_if.sv
// ----------------------------------------------------------------------------
// gsp_cmd_if: command channel
// Valid/ready channel carrying one command word into the PID core.
// ----------------------------------------------------------------------------
interface gsp_cmd_if;
	import gsp_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	sig_t  target;
	sig_t  measured;
	sig_t  schedule_value;
	sig_t  region_threshold;
	sig_t  gain_p;
	sig_t  gain_i;
	sig_t  gain_d;
	sig_t  limit_low;
	sig_t  limit_high;

	modport source (
		output valid, func, target, measured, schedule_value, region_threshold,
		       gain_p, gain_i, gain_d, limit_low, limit_high,
		input  ready
	);
	modport sink (
		input  valid, func, target, measured, schedule_value, region_threshold,
		       gain_p, gain_i, gain_d, limit_low, limit_high,
		output ready
	);
endinterface

// ----------------------------------------------------------------------------
// gsp_res_if: result channel
// Valid/ready channel carrying one result word out of the PID core.
// ----------------------------------------------------------------------------
interface gsp_res_if;
	import gsp_pkg::*;

	logic       valid;
	logic       ready;
	sig_t       drive;
	logic [1:0] region_now;
	status_t    status;
	logic       clamped;

	modport source (output valid, drive, region_now, status, clamped, input ready);
	modport sink   (input valid, drive, region_now, status, clamped, output ready);
endinterface

>>> hdl/gain_scheduled_pid_core.sv
// ----------------------------------------------------------------------------
// gain_scheduled_pid_core: gain-scheduled PID controller
// Region table lookup, Q24.8 saturating integral, derivative and clamped
// output, all products through one shared 35x17 multiplier.
// ----------------------------------------------------------------------------
// Sequence: a step word passes decode, a serial scan of 1..MAX_REGIONS regions,
//   five shared multiplies, the D-term add and the clamp before its result.
//   Append, clear and no-region words go from decode straight to done.
// Throughput: one word at a time; the next word is accepted once the result
//   is in the output register, even while that result waits.
// Reset: region table empty, integral and previous error zero, config at
//   its default values; table entries are not cleared.
// ----------------------------------------------------------------------------
module gain_scheduled_pid_core #(
	parameter int MAX_REGIONS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	gsp_cmd_if.sink           cmd,
	gsp_res_if.source         res,
	input  logic              cfg_we,
	input  gsp_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]       cfg_data
);
	import gsp_pkg::*;

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);

	gsp_state_t state_q, state_d;

	// config
	logic [15:0] step_time_q, rate_hz_q;
	logic        clear_sw_q, windup_q;

	// region table
	sig_t thr_q [MAX_REGIONS];
	sig_t gp_q  [MAX_REGIONS];
	sig_t gi_q  [MAX_REGIONS];
	sig_t gd_q  [MAX_REGIONS];
	sig_t lo_q  [MAX_REGIONS];
	sig_t hi_q  [MAX_REGIONS];

	logic [CW-1:0] count_q;
	logic [IW-1:0] active_q, idx_q;

	logic signed [INT_W-1:0] integ_q, before_q;
	logic signed [ERR_W-1:0] last_q, err_q;
	logic signed [DER_W-1:0] deriv_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;

	// captured command word
	func_t func_q;
	sig_t  target_q, measured_q, sched_q;
	sig_t  thr_in_q, gp_in_q, gi_in_q, gd_in_q, lo_in_q, hi_in_q;

	// result staging and output register
	sig_t    drive_q, out_drive_q;
	status_t status_q, out_status_q;
	logic    clamped_q, out_clamped_q;
	logic [1:0] out_region_q;
	logic    out_valid_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic                   load_res;
	logic                   hit;
	logic                   table_full;
	logic signed [DER_W-1:0] incr;
	logic signed [DER_W-1:0] integ_sum;
	logic signed [INT_W-1:0] integ_sat;
	logic signed [ACC_W-1:0] term_i;
	logic signed [ACC_W-1:0] term_pd;
	logic signed [ACC_W-1:0] lim_hi, lim_lo;

	assign hit        = (sched_q >= thr_q[idx_q]) || (idx_q == '0);
	assign table_full = count_q >= CW'(MAX_REGIONS);
	assign incr       = $signed(prod_q[DER_W+7:8]);
	assign integ_sum  = DER_W'(integ_q) + incr;
	assign term_i     = ACC_W'($signed(prod_q[PROD_W-1:16]));
	assign term_pd    = $signed(prod_q[ACC_W+7:8]);
	assign lim_hi     = ACC_W'(hi_q[active_q]);
	assign lim_lo     = ACC_W'(lo_q[active_q]);

	always_comb begin
		if (integ_sum[DER_W-1:INT_W-1] == '0 || integ_sum[DER_W-1:INT_W-1] == '1) begin
			integ_sat = integ_sum[INT_W-1:0];
		end else if (integ_sum[DER_W-1]) begin
			integ_sat = {1'b1, {(INT_W-1){1'b0}}};
		end else begin
			integ_sat = {1'b0, {(INT_W-1){1'b1}}};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (cmd.valid) state_d = S_DECODE;
			S_DECODE:  begin
				if (func_q == FN_STEP && count_q != '0) begin
					state_d = S_SEARCH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SEARCH:  if (hit) state_d = S_MUL_INC;
			S_MUL_INC: state_d = S_MUL_DRV;
			S_MUL_DRV: state_d = S_MUL_P;
			S_MUL_P:   state_d = S_MUL_I;
			S_MUL_I:   state_d = S_MUL_D;
			S_MUL_D:   state_d = S_ADD_D;
			S_ADD_D:   state_d = S_CLAMP;
			S_CLAMP:   state_d = S_DONE;
			S_DONE:    if (load_res) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs and shared multiplier operands
	always_comb begin
		cmd.ready = 1'b0;
		load_res  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE:    cmd.ready = 1'b1;
			S_MUL_INC: begin
				mul_a = MA_W'(err_q);
				mul_b = {1'b0, step_time_q};
			end
			S_MUL_DRV: begin
				mul_a = MA_W'(DIFF_W'(err_q) - DIFF_W'(last_q));
				mul_b = {1'b0, rate_hz_q};
			end
			S_MUL_P:   begin
				mul_a = MA_W'(err_q);
				mul_b = MB_W'(gp_q[active_q]);
			end
			S_MUL_I:   begin
				mul_a = MA_W'(integ_q);
				mul_b = MB_W'(gi_q[active_q]);
			end
			S_MUL_D:   begin
				mul_a = MA_W'(deriv_q);
				mul_b = MB_W'(gd_q[active_q]);
			end
			S_DONE:    load_res = !out_valid_q || res.ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= 16'd655;
			rate_hz_q   <= 16'd100;
			clear_sw_q  <= 1'b1;
			windup_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_TIME: step_time_q <= cfg_data;
				CFG_RATE_HZ:   rate_hz_q   <= cfg_data;
				CFG_CLEAR_SW:  clear_sw_q  <= cfg_data[0];
				CFG_WINDUP:    windup_q    <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// command capture and region table, no reset
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_q     <= cmd.func;
			target_q   <= cmd.target;
			measured_q <= cmd.measured;
			sched_q    <= cmd.schedule_value;
			thr_in_q   <= cmd.region_threshold;
			gp_in_q    <= cmd.gain_p;
			gi_in_q    <= cmd.gain_i;
			gd_in_q    <= cmd.gain_d;
			lo_in_q    <= cmd.limit_low;
			hi_in_q    <= cmd.limit_high;
		end
		if (state_q == S_DECODE && func_q == FN_APPEND && !table_full) begin
			thr_q[IW'(count_q)] <= thr_in_q;
			gp_q[IW'(count_q)]  <= gp_in_q;
			gi_q[IW'(count_q)]  <= gi_in_q;
			gd_q[IW'(count_q)]  <= gd_in_q;
			lo_q[IW'(count_q)]  <= lo_in_q;
			hi_q[IW'(count_q)]  <= hi_in_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_DECODE:  begin
				err_q     <= ERR_W'(target_q) - ERR_W'(measured_q);
				drive_q   <= '0;
				clamped_q <= 1'b0;
				idx_q     <= IW'(count_q - 1'b1);
				status_q  <= ST_OK;
				if (func_q == FN_STEP && count_q == '0) begin
					status_q <= ST_NO_REGION;
				end else if (func_q == FN_APPEND && table_full) begin
					status_q <= ST_FULL;
				end
			end
			S_SEARCH:  if (!hit) idx_q <= idx_q - 1'b1;
			S_MUL_P:   deriv_q <= prod_q[DER_W-1:0];
			S_MUL_I:   acc_q <= term_pd;
			S_MUL_D:   acc_q <= acc_q + term_i;
			S_ADD_D:   acc_q <= acc_q + term_pd;
			S_CLAMP:   begin
				if (acc_q > lim_hi) begin
					drive_q   <= hi_q[active_q];
					clamped_q <= 1'b1;
				end else if (acc_q < lim_lo) begin
					drive_q   <= lo_q[active_q];
					clamped_q <= 1'b1;
				end else begin
					drive_q   <= acc_q[SIG_W-1:0];
				end
			end
			default:   ;
		endcase
	end

	// dynamic controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= '0;
			integ_q  <= '0;
			before_q <= '0;
			last_q   <= '0;
		end else begin
			unique case (state_q)
				S_DECODE:  begin
					if (func_q == FN_APPEND && !table_full) begin
						count_q <= count_q + 1'b1;
					end
					if (func_q == FN_CLEAR) begin
						integ_q <= '0;
						last_q  <= '0;
					end
				end
				S_SEARCH:  begin
					if (hit && idx_q != active_q) begin
						active_q <= idx_q;
						if (clear_sw_q) integ_q <= '0;
					end
				end
				S_MUL_INC: before_q <= integ_q;
				S_MUL_DRV: begin
					integ_q <= integ_sat;
					last_q  <= err_q;
				end
				S_CLAMP:   begin
					if (windup_q && (acc_q > lim_hi || acc_q < lim_lo)) begin
						integ_q <= before_q;
					end
				end
				default:   ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			out_drive_q   <= drive_q;
			out_status_q  <= status_q;
			out_clamped_q <= clamped_q;
			out_region_q  <= 2'(active_q);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.drive      = out_drive_q;
	assign res.status     = out_status_q;
	assign res.clamped    = out_clamped_q;
	assign res.region_now = out_region_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count beyond table depth");

	a_active_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 || CW'(active_q) < count_q)
		else $error("active region outside filled table");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> CW'(idx_q) < count_q)
		else $error("region scan outside filled table");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_drive_q == '0 && !out_clamped_q)
		else $error("error status word carries a drive value");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECODE |=> state_q != S_IDLE)
		else $error("decode returned to idle without a result");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: gain-scheduled PID core testbench
// Drives command words through the valid/ready channel and checks every
// result word against a cycle-free model of the controller: region lookup,
// saturating Q24.8 integral, scaled derivative, clamp and anti-windup.
// Directed checks of the empty table, table build, full table, anti-windup
// and zero period/rate run first. Random phases with varied register
// settings and random idle/stall patterns on both channels follow.
// ----------------------------------------------------------------------------
module tb;
	import gsp_pkg::*;

	localparam int N_REGIONS     = 4;
	localparam int SETTLE_CYCLES = 20;
	localparam int RUN_LIMIT     = 15000000;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 135;
	localparam func_t FN_NONE    = 2'd3;
	localparam longint SAT_HI    = 64'sd2147483647;
	localparam longint SAT_LO    = -64'sd2147483648;

	typedef struct {
		func_t func;
		sig_t  target;
		sig_t  measured;
		sig_t  schedule_value;
		sig_t  region_threshold;
		sig_t  gain_p;
		sig_t  gain_i;
		sig_t  gain_d;
		sig_t  limit_low;
		sig_t  limit_high;
	} pid_cmd_t;

	typedef struct {
		sig_t       drive;
		logic [1:0] region_now;
		status_t    status;
		logic       clamped;
	} pid_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [15:0] cfg_data;

	gsp_cmd_if cmd_ch ();
	gsp_res_if res_ch ();

	gain_scheduled_pid_core #(.MAX_REGIONS(N_REGIONS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// controller model state
	sig_t               tbl_thr [N_REGIONS];
	sig_t               tbl_kp  [N_REGIONS];
	sig_t               tbl_ki  [N_REGIONS];
	sig_t               tbl_kd  [N_REGIONS];
	sig_t               tbl_lo  [N_REGIONS];
	sig_t               tbl_hi  [N_REGIONS];
	int                 n_regions;
	logic [1:0]         cur_region;
	logic signed [31:0] integ;
	logic signed [16:0] prev_err;
	logic [15:0]        cfg_dt;
	logic [15:0]        cfg_rate;
	logic               cfg_clr;
	logic               cfg_aw;

	pid_res_t pending_results[$];
	int       err_count;
	int       words_sent;
	int       words_seen;
	logic     src_idle_en;
	logic     sink_stall_en;
	int       stall_left;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("tb: mismatch: %s", msg);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic sig_t pick_sig();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'sh7FFF;
		if (r == 1)
			return 16'sh8000;
		return sig_t'($urandom_range(0, 65535));
	endfunction

	function automatic pid_cmd_t make_word(input func_t f);
		pid_cmd_t c;
		c.func             = f;
		c.target           = pick_sig();
		c.measured         = pick_sig();
		c.schedule_value   = pick_sig();
		c.region_threshold = pick_sig();
		c.gain_p           = pick_sig();
		c.gain_i           = pick_sig();
		c.gain_d           = pick_sig();
		c.limit_low        = pick_sig();
		c.limit_high       = pick_sig();
		return c;
	endfunction

	function automatic pid_cmd_t step_word(input sig_t t, input sig_t m, input sig_t s);
		pid_cmd_t c;
		c = make_word(FN_STEP);
		c.target         = t;
		c.measured       = m;
		c.schedule_value = s;
		return c;
	endfunction

	function automatic pid_cmd_t region_word(input sig_t thr, input sig_t kp, input sig_t ki,
			input sig_t kd, input sig_t lo, input sig_t hi);
		pid_cmd_t c;
		c = make_word(FN_APPEND);
		c.region_threshold = thr;
		c.gain_p           = kp;
		c.gain_i           = ki;
		c.gain_d           = kd;
		c.limit_low        = lo;
		c.limit_high       = hi;
		return c;
	endfunction

	// advances the model by one command word and returns the expected result
	function automatic pid_res_t predict_pid_result(input pid_cmd_t c);
		pid_res_t           r;
		longint             err;
		longint             acc;
		longint             deriv;
		longint             sum;
		logic signed [31:0] saved;
		int                 sel;
		r.drive   = '0;
		r.status  = ST_OK;
		r.clamped = 1'b0;
		case (c.func)
			FN_STEP: begin
				if (n_regions == 0) begin
					r.status = ST_NO_REGION;
				end else begin
					sel = 0;
					for (int i = 0; i < n_regions; i++)
						if (c.schedule_value >= tbl_thr[i])
							sel = i;
					if (sel != cur_region) begin
						if (cfg_clr)
							integ = '0;
						cur_region = sel[1:0];
					end
					err   = longint'(c.target) - longint'(c.measured);
					saved = integ;
					acc   = longint'(integ) + ((err * longint'(cfg_dt)) >>> 8);
					if (acc > SAT_HI)
						integ = 32'sh7FFFFFFF;
					else if (acc < SAT_LO)
						integ = 32'sh80000000;
					else
						integ = acc[31:0];
					deriv    = (err - longint'(prev_err)) * longint'(cfg_rate);
					prev_err = err[16:0];
					sum = ((longint'(tbl_kp[sel]) * err) >>> 8)
						+ ((longint'(tbl_ki[sel]) * longint'(integ)) >>> 16)
						+ ((longint'(tbl_kd[sel]) * deriv) >>> 8);
					if (sum > longint'(tbl_hi[sel])) begin
						sum       = longint'(tbl_hi[sel]);
						r.clamped = 1'b1;
					end else if (sum < longint'(tbl_lo[sel])) begin
						sum       = longint'(tbl_lo[sel]);
						r.clamped = 1'b1;
					end
					if (r.clamped && cfg_aw)
						integ = saved;
					r.drive = sum[15:0];
				end
			end
			FN_APPEND: begin
				if (n_regions >= N_REGIONS) begin
					r.status = ST_FULL;
				end else begin
					tbl_thr[n_regions] = c.region_threshold;
					tbl_kp[n_regions]  = c.gain_p;
					tbl_ki[n_regions]  = c.gain_i;
					tbl_kd[n_regions]  = c.gain_d;
					tbl_lo[n_regions]  = c.limit_low;
					tbl_hi[n_regions]  = c.limit_high;
					n_regions++;
				end
			end
			FN_CLEAR: begin
				integ    = '0;
				prev_err = '0;
			end
			default: ;
		endcase
		r.region_now = cur_region;
		return r;
	endfunction

	// entered and left at a rising edge; leaves valid high
	task automatic send_word(input pid_cmd_t c);
		int gap;
		gap = src_idle_en ? idle_len() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid            <= 1'b1;
		cmd_ch.func             <= c.func;
		cmd_ch.target           <= c.target;
		cmd_ch.measured         <= c.measured;
		cmd_ch.schedule_value   <= c.schedule_value;
		cmd_ch.region_threshold <= c.region_threshold;
		cmd_ch.gain_p           <= c.gain_p;
		cmd_ch.gain_i           <= c.gain_i;
		cmd_ch.gain_d           <= c.gain_d;
		cmd_ch.limit_low        <= c.limit_low;
		cmd_ch.limit_high       <= c.limit_high;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		pending_results.push_back(predict_pid_result(c));
		words_sent++;
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// only called once the core is idle
	task automatic load_config(input logic [15:0] dt, input logic [15:0] rate,
			input logic clr, input logic aw);
		put_reg(CFG_STEP_TIME, dt);
		put_reg(CFG_RATE_HZ, rate);
		put_reg(CFG_CLEAR_SW, {15'd0, clr});
		put_reg(CFG_WINDUP, {15'd0, aw});
		cfg_we   <= 1'b0;
		cfg_dt   = dt;
		cfg_rate = rate;
		cfg_clr  = clr;
		cfg_aw   = aw;
	endtask

	// result side: random back-pressure and the compare
	always @(posedge clk) begin
		pid_res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result word with no command pending");
				end else begin
					want = pending_results.pop_front();
					if (res_ch.drive !== want.drive)
						report_mismatch($sformatf("word %0d drive %0d, want %0d",
							words_seen, res_ch.drive, want.drive));
					if (res_ch.region_now !== want.region_now)
						report_mismatch($sformatf("word %0d region_now %0d, want %0d",
							words_seen, res_ch.region_now, want.region_now));
					if (res_ch.status !== want.status)
						report_mismatch($sformatf("word %0d status %0d, want %0d",
							words_seen, res_ch.status, want.status));
					if (res_ch.clamped !== want.clamped)
						report_mismatch($sformatf("word %0d clamped %0b, want %0b",
							words_seen, res_ch.clamped, want.clamped));
				end
				words_seen++;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (sink_stall_en)
					stall_left = idle_len();
			end
		end
	end

	task automatic test_empty_table();
		send_word(step_word(16'sh0100, 16'sh0000, 16'sh0000));
		send_word(make_word(FN_NONE));
		send_word(make_word(FN_CLEAR));
	endtask

	task automatic test_table_build();
		send_word(region_word(16'sh8000, 16'sh0100, 16'sh7FFF, 16'sh8000,
			16'sh8000, 16'sh7FFF));
		send_word(step_word(16'sh7FFF, 16'sh8000, 16'sh0000));
		send_word(step_word(16'sh8000, 16'sh7FFF, 16'sh7FFF));
		send_word(region_word(-16'sd256, 16'sh8000, 16'sh8000, 16'sh7FFF,
			-16'sd1024, 16'sd1024));
		send_word(step_word(16'sh0040, 16'sh0000, 16'sh0000));
		send_word(step_word(16'sh0040, 16'sh0020, 16'sh8000));
		// low limit above high limit
		send_word(region_word(16'sd256, 16'sd512, 16'sd128, 16'sd16,
			16'sd2000, -16'sd2000));
		send_word(step_word(16'sd100, 16'sd0, 16'sd1000));
		send_word(step_word(16'sd0, 16'sd0, 16'sd1000));
		send_word(region_word(sig_t'($urandom_range(512, 32767)), pick_sig(), pick_sig(),
			pick_sig(), -16'sd20000, 16'sd20000));
		send_word(step_word(16'sh1234, 16'shF000, 16'sh7FFF));
	endtask

	task automatic test_table_full();
		send_word(make_word(FN_APPEND));
		send_word(step_word(16'sh0200, 16'sh0100, 16'sh0000));
	endtask

	task automatic test_windup();
		settle();
		load_config(16'd655, 16'd100, 1'b0, 1'b1);
		send_word(step_word(16'sh4000, 16'shC000, 16'sh0000));
		send_word(step_word(16'sh4000, 16'shC000, 16'sh0000));
		send_word(step_word(16'sh0001, 16'sh0000, 16'sh0000));
	endtask

	task automatic test_zero_period();
		settle();
		load_config(16'd0, 16'd0, 1'b1, 1'b0);
		send_word(step_word(16'sh7FFF, 16'sh8000, 16'sh0000));
		send_word(make_word(FN_CLEAR));
		send_word(step_word(16'sh8000, 16'sh7FFF, 16'sd300));
	endtask

	task automatic test_random_traffic();
		pid_cmd_t    c;
		int          in_phase;
		int          run_len;
		int          bias;
		int          phase_bias;
		sig_t        sched_base;
		sig_t        pos;
		sig_t        neg;
		logic [15:0] dt;
		logic [15:0] rate;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase % 4)
				0: dt = 16'd1;
				1: dt = 16'hFFFF;
				2: dt = 16'($urandom_range(1, 65535));
				default: dt = 16'd655;
			endcase
			case (phase % 3)
				0: rate = 16'd1;
				1: rate = 16'hFFFF;
				default: rate = 16'($urandom_range(1, 2000));
			endcase
			load_config(dt, rate, ((phase / 3) % 2) == 1, ((phase / 6) % 2) == 1);
			src_idle_en   = (phase % 5) != 2;
			sink_stall_en = (phase % 5) != 4;
			phase_bias    = $urandom_range(0, 1) ? 1 : -1;
			in_phase      = 0;
			while (in_phase < PHASE_WORDS) begin
				run_len    = $urandom_range(4, 40);
				sched_base = tbl_thr[$urandom_range(0, N_REGIONS - 1)]
					+ sig_t'($urandom_range(0, 8));
				bias       = ($urandom_range(0, 3) != 0) ? phase_bias : -phase_bias;
				for (int j = 0; j < run_len; j++) begin
					c = make_word(FN_STEP);
					case ($urandom_range(0, 39))
						0: c.func = FN_CLEAR;
						1: c.func = FN_APPEND;
						2: c.func = FN_NONE;
						3, 4, 5: ;
						default: begin
							c.schedule_value = sched_base;
							if ($urandom_range(0, 3) == 0) begin
								c.target   = sig_t'($urandom_range(0, 511)) - 16'sd256;
								c.measured = sig_t'($urandom_range(0, 511)) - 16'sd256;
							end else begin
								pos = sig_t'($urandom_range(0, 32767));
								neg = sig_t'(-int'($urandom_range(1, 32768)));
								c.target   = (bias > 0) ? pos : neg;
								c.measured = (bias > 0) ? neg : pos;
							end
						end
					endcase
					send_word(c);
					if (c.func == FN_STEP || c.func == FN_CLEAR)
						in_phase++;
				end
			end
		end
	endtask

	initial begin
		int waited;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_STEP_TIME;
		cfg_data      = '0;
		cmd_ch.valid            = 1'b0;
		cmd_ch.func             = FN_STEP;
		cmd_ch.target           = '0;
		cmd_ch.measured         = '0;
		cmd_ch.schedule_value   = '0;
		cmd_ch.region_threshold = '0;
		cmd_ch.gain_p           = '0;
		cmd_ch.gain_i           = '0;
		cmd_ch.gain_d           = '0;
		cmd_ch.limit_low        = '0;
		cmd_ch.limit_high       = '0;
		res_ch.ready  = 1'b0;
		n_regions     = 0;
		cur_region    = '0;
		integ         = '0;
		prev_err      = '0;
		cfg_dt        = 16'd655;
		cfg_rate      = 16'd100;
		cfg_clr       = 1'b1;
		cfg_aw        = 1'b0;
		err_count     = 0;
		words_sent    = 0;
		words_seen    = 0;
		stall_left    = 0;
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
		waited        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_table_build();
		test_table_full();
		test_windup();
		test_zero_period();
		test_random_traffic();

		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb: timeout");
		$display("tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/gsp_pkg.sv
hdl/gsp_cmd_if.sv
hdl/gain_scheduled_pid_core.sv
test/tb.sv
